>>> rtl/lge_pkg.sv
// Shared types and constants for the life grid engine.
package lge_pkg;

  localparam int GRID_WIDTH_DEF  = 32;
  localparam int GRID_HEIGHT_DEF = 32;

  localparam int ACT_W    = 2;
  localparam int COORD_W  = 5;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_READ  = 2'd3
  } lge_action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_CELL_RD,
    S_CELL_GET,
    S_STEP,
    S_DONE
  } lge_state_t;

  typedef struct packed {
    logic load_req;
    logic clr_grid;
    logic cnt_clr;
    logic step_run;
    logic rmw_rd;
    logic rmw_wr;
    logic cell_rd;
    logic res_get;
    logic out_load;
  } lge_cmd_t;

  typedef struct packed {
    logic in_range;
    logic step_last;
  } lge_status_t;

endpackage

>>> rtl/lge_ctrl.sv
// Controller state machine that sequences each request of the life grid engine.
module lge_ctrl
  import lge_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  lge_action_t req_action,
  output logic        res_valid,
  input  logic        res_ready,
  input  lge_status_t status,
  output lge_cmd_t    cmd
);

  lge_state_t state;
  lge_state_t state_next;
  logic       out_free;

  assign out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_action)
            ACT_WRITE: state_next = S_RMW_RD;
            ACT_CLEAR: state_next = S_DONE;
            ACT_STEP:  state_next = S_STEP;
            ACT_READ:  state_next = S_CELL_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_RMW_RD:   state_next = status.in_range ? S_RMW_WR : S_DONE;
      S_RMW_WR:   state_next = S_DONE;
      S_CELL_RD:  state_next = S_CELL_GET;
      S_CELL_GET: state_next = S_DONE;
      S_STEP: begin
        if (status.step_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          cmd.clr_grid = (req_action == ACT_CLEAR);
          cmd.cnt_clr  = (req_action == ACT_STEP);
        end
      end
      S_RMW_RD:   cmd.rmw_rd = status.in_range;
      S_RMW_WR:   cmd.rmw_wr = 1'b1;
      S_CELL_RD:  cmd.cell_rd = 1'b1;
      S_CELL_GET: cmd.res_get = 1'b1;
      S_STEP:     cmd.step_run = 1'b1;
      S_DONE:     cmd.out_load = out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

>>> rtl/lge_dp.sv
// Datapath of the life grid engine: row memory, three-row window and rule logic.
module lge_dp
  import lge_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COORD_W-1:0] req_col,
  input  logic [COORD_W-1:0] req_row,
  input  logic               req_cell,
  input  lge_cmd_t           cmd,
  output lge_status_t        status,
  output logic               cell_out
);

  localparam int RAW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int CW  = $clog2(GRID_HEIGHT + 2);

  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_HEIGHT-1:0] row_valid;

  logic [COORD_W-1:0]    col_q;
  logic [COORD_W-1:0]    row_q;
  logic                  cell_q;
  logic [CW-1:0]         cnt;
  logic [GRID_WIDTH-1:0] rd_word;
  logic                  rd_valid;
  logic [GRID_WIDTH-1:0] rd_row;
  logic [GRID_WIDTH-1:0] win_prev;
  logic [GRID_WIDTH-1:0] win_cur;
  logic [GRID_WIDTH-1:0] win_nxt;
  logic [GRID_WIDTH-1:0] gen_row;
  logic [GRID_WIDTH-1:0] cell_mask;
  logic [GRID_WIDTH-1:0] rmw_row;
  logic [GRID_WIDTH-1:0] rd_shifted;
  logic [GRID_WIDTH-1:0] wr_data;
  logic [RAW-1:0]        req_addr;
  logic [RAW-1:0]        rd_addr;
  logic [RAW-1:0]        wr_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic                  step_rd;
  logic                  step_shift;
  logic                  step_wr;
  logic                  in_range;
  logic                  res;

  assign in_range = (32'(col_q) < 32'(GRID_WIDTH)) && (32'(row_q) < 32'(GRID_HEIGHT));
  assign req_addr = RAW'(row_q);

  assign step_rd    = cmd.step_run && (cnt < CW'(GRID_HEIGHT));
  assign step_shift = cmd.step_run && (cnt >= CW'(1)) && (cnt <= CW'(GRID_HEIGHT));
  assign step_wr    = cmd.step_run && (cnt >= CW'(4)) && (cnt <= CW'(GRID_HEIGHT + 1));

  assign status.in_range  = in_range;
  assign status.step_last = (cnt == CW'(GRID_HEIGHT + 1));

  assign rd_en   = cmd.rmw_rd || cmd.cell_rd || step_rd;
  assign rd_addr = cmd.step_run ? RAW'(cnt) : req_addr;
  assign rd_row  = rd_valid ? rd_word : '0;

  assign cell_mask  = GRID_WIDTH'(1) << col_q;
  assign rmw_row    = (rd_row & ~cell_mask) | (cell_q ? cell_mask : '0);
  assign rd_shifted = rd_row >> col_q;

  assign wr_en   = cmd.rmw_wr || step_wr;
  assign wr_addr = cmd.rmw_wr ? req_addr : RAW'(cnt - CW'(3));
  assign wr_data = cmd.rmw_wr ? rmw_row : gen_row;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      col_q  <= req_col;
      row_q  <= req_row;
      cell_q <= req_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.step_run) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word  <= mem[rd_addr];
      rd_valid <= row_valid[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_grid) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_shift) begin
      win_prev <= win_cur;
      win_cur  <= win_nxt;
      win_nxt  <= rd_row;
    end
  end

  always_comb begin
    logic [3:0] n;
    n       = '0;
    gen_row = win_cur;
    for (int c = 1; c < GRID_WIDTH - 1; c++) begin
      n = 4'(win_prev[c-1]) + 4'(win_prev[c]) + 4'(win_prev[c+1])
        + 4'(win_cur[c-1]) + 4'(win_cur[c+1])
        + 4'(win_nxt[c-1]) + 4'(win_nxt[c]) + 4'(win_nxt[c+1]);
      gen_row[c] = (n == 4'd3) || (win_cur[c] && (n == 4'd2));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      res <= 1'b0;
    end else if (cmd.res_get) begin
      res <= rd_shifted[0] && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cell_out <= res;
    end
  end

endmodule

>>> rtl/life_grid_engine_top.sv
// Top level of the life grid engine: stream ports, controller and datapath.
//
// The engine holds a GRID_WIDTH by GRID_HEIGHT grid of cells, all dead after
// reset, and answers every request with exactly one result, which is the
// addressed cell on a read and 0 otherwise. A cell write reads the addressed
// row and writes it back with the new cell; a cell read reads the row and
// then picks out the cell. The grid lives in a row memory with one read and
// one write port, and a generation step streams one row per cycle through a
// three-row window while writing back the new rows behind it.
// Border cells keep their value on a step. One request is worked on at a
// time; the result register lets the next request in while a result waits.
module life_grid_engine_top
  import lge_pkg::*;
#(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // action[1:0], col[6:2], row[11:7], cell_in[12]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata   // cell_out[0]
);

  lge_cmd_t    cmd;
  lge_status_t status;
  lge_action_t action;
  logic        cell_out;

  assign action = lge_action_t'(s_tdata[1:0]);
  assign m_tdata = {(OUT_TDATA_W - 1)'(0), cell_out};

  lge_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .req_action (action),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lge_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_col  (s_tdata[6:2]),
    .req_row  (s_tdata[11:7]),
    .req_cell (s_tdata[12]),
    .cmd      (cmd),
    .status   (status),
    .cell_out (cell_out)
  );

endmodule
